### hdl/binary_to_decimal_digits_macros.svh
// Assertion macros for the binary to decimal digit converter.
// Each macro places one concurrent assertion, sampled at the rising clock
// edge and disabled while the active-low reset is asserted.
`ifndef BINARY_TO_DECIMAL_DIGITS_MACROS_SVH
`define BINARY_TO_DECIMAL_DIGITS_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define B2DD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B2DD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define B2DD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define B2DD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hdl/b2dd_pkg.sv
package b2dd_pkg;

	localparam int BIN_W      = 64;
	localparam int NUM_DIGITS = 20;
	localparam int DIGIT_W    = 4;
	localparam int POS_W      = 5;
	localparam int CNT_W      = 6;

	// Control shared by every digit cell in the chain.
	typedef struct packed {
		logic clear;
		logic dabble;
		logic drain;
	} cell_ctrl_t;

endpackage

### hdl/b2dd_req_if.sv
interface b2dd_req_if import b2dd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BIN_W-1:0]   value;
	logic               signed_mode;

	modport source (output valid, value, signed_mode, input ready);
	modport sink (input valid, value, signed_mode, output ready);
endinterface

### hdl/b2dd_res_if.sv
interface b2dd_res_if import b2dd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DIGIT_W-1:0] digit;
	logic [POS_W-1:0]   position;
	logic               negative;
	logic               last;

	modport source (output valid, digit, position, negative, last, input ready);
	modport sink (input valid, digit, position, negative, last, output ready);
endinterface

### hdl/b2dd_cell.sv
module b2dd_cell import b2dd_pkg::*; (
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic               shift_in,
	output logic               shift_out,
	input  logic [DIGIT_W-1:0] upper_digit,
	output logic [DIGIT_W-1:0] digit,
	input  logic               nz_in,
	output logic               nz_out
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// Add three to a digit of five or more so that the next doubling carries out.
	always_comb begin
		adj = (digit_q >= DIGIT_W'(5)) ? digit_q + DIGIT_W'(3) : digit_q;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[DIGIT_W-2:0], shift_in};
		end else if (ctrl.drain) begin
			digit_q <= upper_digit;
		end
	end

	assign shift_out = adj[DIGIT_W-1];
	assign digit     = digit_q;
	assign nz_out    = nz_in | (digit_q != '0);

endmodule

### hdl/binary_to_decimal_digits.sv
// Binary to decimal digit converter.
// A request on the req channel carries a 64-bit value and a signed_mode bit.
// The block takes the magnitude of the value (two's complement negation when
// signed_mode is set and bit 63 is one) and emits its decimal digits on the
// res channel, least significant first, one result per digit. Each result
// carries the digit value 0 to 9, its position from the units place, the
// negative flag, and last on the most significant digit. Zero gives one
// digit 0 with last set.
// Timing: a request is taken while the block is idle, then the magnitude is
// shifted through a chain of twenty BCD digit cells, one bit per cycle, until
// every bit of the value has entered the chain. The digits are then offered
// one digit per cycle while the receiver is ready. One request is in work at
// a time, and req.ready is high only while the block is idle.
// The receiver may stall at any time: the current digit simply holds on the
// outputs until res.ready is seen, and the chain does not move.
// Reset clears the control state; the block comes out idle with req.ready
// high and res.valid low.
`include "binary_to_decimal_digits_macros.svh"

module binary_to_decimal_digits import b2dd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	b2dd_req_if.sink    req,
	b2dd_res_if.source  res
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_DRAIN
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [POS_W-1:0]   pos_q;
	logic               neg_q;
	logic [BIN_W-1:0]   bin_q;

	logic               accept;
	logic               in_neg;
	logic [BIN_W-1:0]   in_mag;
	logic               last_digit;
	cell_ctrl_t         ctrl;

	// Shift chain between cells: entry i feeds cell i, entry i+1 is its carry out.
	logic               sh [NUM_DIGITS+1];
	// Digit chain: cell i loads entry i+1 while draining toward the units place.
	logic [DIGIT_W-1:0] dig_w [NUM_DIGITS+1];
	// Nonzero chain: entry i is set when cell i or any cell above holds a nonzero digit.
	logic               nz [NUM_DIGITS+1];

	assign accept = req.valid & req.ready;
	assign in_neg = req.signed_mode & req.value[BIN_W-1];
	assign in_mag = in_neg ? (~req.value + BIN_W'(1)) : req.value;

	// The units digit is the last one once nothing nonzero remains above it.
	assign last_digit = ~nz[1];

	always_comb begin
		ctrl.clear  = accept;
		ctrl.dabble = (state_q == ST_CONVERT);
		ctrl.drain  = (state_q == ST_DRAIN) & res.ready & ~last_digit;
	end

	assign sh[0]              = bin_q[BIN_W-1];
	assign dig_w[NUM_DIGITS]  = '0;
	assign nz[NUM_DIGITS]     = 1'b0;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		b2dd_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.shift_in    (sh[i]),
			.shift_out   (sh[i+1]),
			.upper_digit (dig_w[i+1]),
			.digit       (dig_w[i]),
			.nz_in       (nz[i+1]),
			.nz_out      (nz[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			neg_q   <= 1'b0;
			bin_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bin_q   <= in_mag;
						neg_q   <= in_neg;
						cnt_q   <= '0;
						pos_q   <= '0;
						state_q <= ST_CONVERT;
					end
				end
				ST_CONVERT: begin
					bin_q <= {bin_q[BIN_W-2:0], 1'b0};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(BIN_W - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (res.ready) begin
						if (last_digit) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q <= pos_q + POS_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready    = (state_q == ST_IDLE);
	assign res.valid    = (state_q == ST_DRAIN);
	assign res.digit    = dig_w[0];
	assign res.position = pos_q;
	assign res.negative = neg_q;
	assign res.last     = last_digit;

	// A value of at most twenty digits never carries out of the top cell.
	`B2DD_ASSERT_SAME(a_no_overflow, clk, arst_n, state_q == ST_CONVERT, !sh[NUM_DIGITS], "carry out of the top digit cell")
	// Only valid decimal digits are offered.
	`B2DD_ASSERT_SAME(a_digit_range, clk, arst_n, res.valid, res.digit <= DIGIT_W'(9), "digit above nine")
	// The twentieth digit is always the most significant one.
	`B2DD_ASSERT_SAME(a_last_at_top, clk, arst_n, res.valid && (pos_q == POS_W'(NUM_DIGITS - 1)), res.last, "more than twenty digits")
	// A digit is never offered in the cycle after a request is taken.
	`B2DD_ASSERT_NEXT(a_no_early_result, clk, arst_n, accept, !res.valid, "result right after request")
	// The sign flag holds across all digits of one conversion.
	`B2DD_ASSERT_NEXT(a_sign_steady, clk, arst_n, res.valid && res.ready && !res.last, res.valid && (res.negative == $past(res.negative)), "sign changed within a conversion")

endmodule
